/* rtl/unsigned_dec_hex_text_parser_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned decimal / hexadecimal text parser
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DEC_HEX_TEXT_PARSER_MACROS_SVH
`define UNSIGNED_DEC_HEX_TEXT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UDHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/udhp_pkg.sv */
// ----------------------------------------------------------------------------
// udhp_pkg
// Shared constants and types of the unsigned decimal / hexadecimal parser.
// ----------------------------------------------------------------------------
package udhp_pkg;

  // Default accumulator width.
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Width of one text byte and of the result value field.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OUT_W   = 32;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // Classification of one text byte.
  typedef struct packed {
    logic       is_term;   // zero byte
    logic       is_space;  // codes 9 to 13 and 32
    logic       is_zero;   // character '0'
    logic       is_x;      // character 'x' or 'X'
    logic       dec_ok;    // decimal digit
    logic       hex_ok;    // hexadecimal digit of either case
    logic [3:0] digit;     // digit value when dec_ok or hex_ok
  } char_class_t;

endpackage

/* rtl/unsigned_dec_hex_text_parser.sv */
// ----------------------------------------------------------------------------
// unsigned_dec_hex_text_parser
// Parses a zero-terminated text byte stream into an unsigned value.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle unless a terminator faces a full result
//   register; the accumulator closes its loop through a shift-and-add multiply
//   by 10 or 16. Result path: a terminator byte passes the input register,
//   then the result register.
// Reset: valid flags clear and the parser returns to the whitespace phase
//   with a zero accumulator and no error.
`include "unsigned_dec_hex_text_parser_macros.svh"

module unsigned_dec_hex_text_parser #(
  parameter int unsigned VALUE_BITS = udhp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: [7:0] char_code
  input  logic [udhp_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: [31:0] value, [32] error, [39:33] zero
  output logic [udhp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);

  logic                                  in_valid_q;
  logic [udhp_pkg::CHAR_W-1:0]           in_char_q;
  udhp_pkg::char_class_t                 cls;
  logic                                  out_free;
  logic                                  fire;
  logic                                  load_out;
  logic                                  in_xfer;
  logic [VALUE_BITS-1:0]                 acc;
  logic                                  err;
  logic                                  out_valid_q;
  logic [udhp_pkg::OUT_TDATA_W-1:0]      out_data_q;

  // Handshake: a held byte advances unless it is a terminator facing a full
  // result register.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!cls.is_term || out_free);
  assign load_out        = fire && cls.is_term;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_char_q <= s_axis_tdata_i[udhp_pkg::CHAR_W-1:0];
    end
  end

  // Byte classification.
  udhp_char_decode u_decode (
    .char_i (in_char_q),
    .cls_o  (cls)
  );

  // Parse state and accumulator.
  udhp_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .cls_i  (cls),
    .acc_o  (acc),
    .err_o  (err)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {7'd0, err, udhp_pkg::OUT_W'(acc)};
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  // Checks on the parser control.
  `UDHP_ASSERT_NEXT(a_term_gives_result, load_out, out_valid_q, "terminator lost its result")
  `UDHP_ASSERT_SAME(a_no_overwrite, out_valid_q && !m_axis_tready_i, !load_out, "result overwritten")
  `UDHP_ASSERT_NEXT(a_state_cleared, load_out, (acc == '0) && !err, "state not cleared")
  `UDHP_ASSERT_NEXT(a_input_drains, fire && !in_xfer, !in_valid_q, "input byte repeated")

endmodule

/* rtl/udhp_char_decode.sv */
// ----------------------------------------------------------------------------
// udhp_char_decode
// Classifies one text byte and gives its digit value.
// ----------------------------------------------------------------------------
module udhp_char_decode (
  input  logic [udhp_pkg::CHAR_W-1:0] char_i,
  output udhp_pkg::char_class_t       cls_o
);

  logic is_num;
  logic is_lower;
  logic is_upper;

  // Range checks for the digit groups.
  assign is_num   = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_lower = (char_i >= 8'h61) && (char_i <= 8'h66);
  assign is_upper = (char_i >= 8'h41) && (char_i <= 8'h46);

  // Build the class flags and the digit value.
  always_comb begin
    cls_o.is_term  = (char_i == 8'h00);
    cls_o.is_space = (char_i == 8'h20) || ((char_i >= 8'h09) && (char_i <= 8'h0d));
    cls_o.is_zero  = (char_i == 8'h30);
    cls_o.is_x     = (char_i == 8'h78) || (char_i == 8'h58);
    cls_o.dec_ok   = is_num;
    cls_o.hex_ok   = is_num || is_lower || is_upper;
    if (is_num) begin
      cls_o.digit = 4'(char_i - 8'h30);
    end else if (is_lower) begin
      cls_o.digit = 4'(char_i - 8'h57);
    end else if (is_upper) begin
      cls_o.digit = 4'(char_i - 8'h37);
    end else begin
      cls_o.digit = 4'd0;
    end
  end

endmodule

/* rtl/udhp_accum.sv */
// ----------------------------------------------------------------------------
// udhp_accum
// Parse state, digit accumulator and error flag, updated once per byte.
// ----------------------------------------------------------------------------
module udhp_accum #(
  parameter int unsigned VALUE_BITS = udhp_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  udhp_pkg::char_class_t  cls_i,
  output logic [VALUE_BITS-1:0]  acc_o,
  output logic                   err_o
);

  localparam logic [2:0] PH_SPACE = 3'd0;
  localparam logic [2:0] PH_ZERO  = 3'd1;
  localparam logic [2:0] PH_DEC   = 3'd2;
  localparam logic [2:0] PH_HEX   = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;

  localparam int unsigned EXT_W = VALUE_BITS + 4;

  logic [2:0]            phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  err_q, err_d;

  logic [EXT_W-1:0]      acc_ext;
  logic [EXT_W-1:0]      prod10;
  logic [EXT_W-1:0]      prod16;
  logic                  ovf10;
  logic                  ovf16;

  // Multiply-accumulate by shift and add; the top four bits flag overflow.
  assign acc_ext = {4'd0, acc_q};
  assign prod10  = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(cls_i.digit);
  assign prod16  = (acc_ext << 4) + EXT_W'(cls_i.digit);
  assign ovf10   = |prod10[EXT_W-1:VALUE_BITS];
  assign ovf16   = |prod16[EXT_W-1:VALUE_BITS];

  // Next-state logic for one byte.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    err_d   = err_q;
    if (step_i) begin
      if (cls_i.is_term) begin
        phase_d = PH_SPACE;
        acc_d   = '0;
        err_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_SPACE, PH_ZERO, PH_DEC: begin
            if ((phase_q == PH_SPACE) && cls_i.is_space) begin
              phase_d = PH_SPACE;
            end else if ((phase_q == PH_SPACE) && cls_i.is_zero) begin
              phase_d = PH_ZERO;
            end else if ((phase_q == PH_ZERO) && cls_i.is_x) begin
              phase_d = PH_HEX;
            end else if (cls_i.dec_ok) begin
              phase_d = PH_DEC;
              acc_d   = prod10[VALUE_BITS-1:0];
              err_d   = err_q | ovf10;
            end else begin
              phase_d = PH_SKIP;
              err_d   = 1'b1;
            end
          end
          PH_HEX: begin
            if (cls_i.hex_ok) begin
              acc_d = prod16[VALUE_BITS-1:0];
              err_d = err_q | ovf16;
            end else begin
              phase_d = PH_SKIP;
              err_d   = 1'b1;
            end
          end
          default: begin
            phase_d = PH_SKIP;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      acc_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

  assign acc_o = acc_q;
  assign err_o = err_q;

endmodule

/* dv/unsigned_dec_hex_text_parser_chk.sv */
// ----------------------------------------------------------------------------
// Scoreboard for the unsigned decimal / hexadecimal text parser
// Watches both stream channels, tracks the parser state from every input
// transfer, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module unsigned_dec_hex_text_parser_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [udhp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [udhp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      results_o,
  output int unsigned                      flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS = udhp_pkg::VALUE_BITS_DEF;
  localparam int unsigned OUT_W = udhp_pkg::OUT_W;
  localparam int unsigned OUT_TDATA_W = udhp_pkg::OUT_TDATA_W;
  localparam logic [71:0] VALUE_MASK = {72{1'b0}} | ({64{1'b1}} >> (64 - VALUE_BITS));
  localparam logic [7:0] TERMINATOR = 8'h00;
  localparam int unsigned BASE_DEC = 10;
  localparam int unsigned BASE_HEX = 16;

  typedef enum logic [2:0] {
    LEAD_SPACE,
    SAW_ZERO,
    DEC_DIGITS,
    HEX_DIGITS,
    SKIP_REST
  } parse_phase_e;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             error;
  } parsed_number_t;

  parse_phase_e   phase_q = LEAD_SPACE;
  logic [71:0]    acc_q = '0;
  logic           err_q = 1'b0;
  parsed_number_t expected_numbers[$];
  int unsigned    fails = 0;
  int unsigned    pending = 0;
  int unsigned    results = 0;
  int unsigned    flagged = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign results_o    = results;
  assign flagged_o    = flagged;

  // Digit value of a character in the given base, or -1 when it is none.
  function automatic int digit_value(logic [7:0] c, int unsigned base);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (base == BASE_HEX && c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (base == BASE_HEX && c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Accumulate one digit, or flag the character and ignore the rest.
  task automatic take_digit(logic [7:0] c, int unsigned base);
    int          d;
    logic [71:0] sum;
    d = digit_value(c, base);
    if (d < 0) begin
      err_q   = 1'b1;
      phase_q = SKIP_REST;
    end else begin
      sum = acc_q * base + 72'(d);
      if (sum > VALUE_MASK) err_q = 1'b1;
      acc_q = sum & VALUE_MASK;
    end
  endtask

  // Advance the predicted parser by one text byte.
  task automatic parse_char(logic [7:0] c);
    if (c == TERMINATOR) begin
      expected_numbers.push_back('{value: acc_q[OUT_W-1:0], error: err_q});
      phase_q = LEAD_SPACE;
      acc_q   = '0;
      err_q   = 1'b0;
    end else begin
      case (phase_q)
        LEAD_SPACE: begin
          if (c == " " || (c >= "\t" && c <= "\r")) begin
            // Leading whitespace is dropped.
          end else if (c == "0") begin
            phase_q = SAW_ZERO;
          end else begin
            phase_q = DEC_DIGITS;
            take_digit(c, BASE_DEC);
          end
        end
        SAW_ZERO: begin
          if (c == "x" || c == "X") begin
            phase_q = HEX_DIGITS;
          end else begin
            phase_q = DEC_DIGITS;
            take_digit(c, BASE_DEC);
          end
        end
        DEC_DIGITS: take_digit(c, BASE_DEC);
        HEX_DIGITS: take_digit(c, BASE_HEX);
        default: phase_q = SKIP_REST;
      endcase
    end
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_number(logic [OUT_TDATA_W-1:0] data);
    parsed_number_t want;
    if (expected_numbers.size() == 0) begin
      fails++;
      $display("%0t: result with none expected: value %h error %b", $time,
               data[OUT_W-1:0], data[OUT_W]);
    end else begin
      want = expected_numbers.pop_front();
      results++;
      if (want.error) flagged++;
      if (data[OUT_W-1:0] !== want.value) begin
        fails++;
        $display("%0t: value mismatch: expected %h, actual %h", $time,
                 want.value, data[OUT_W-1:0]);
      end
      if (data[OUT_W] !== want.error) begin
        fails++;
        $display("%0t: error flag mismatch: expected %b, actual %b", $time,
                 want.error, data[OUT_W]);
      end
      if (data[OUT_TDATA_W-1:OUT_W+1] !== '0) begin
        fails++;
        $display("%0t: padding mismatch: expected 0, actual %h", $time,
                 data[OUT_TDATA_W-1:OUT_W+1]);
      end
    end
  endtask

  // Results are checked before the same edge's input updates the state.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = LEAD_SPACE;
      acc_q   = '0;
      err_q   = 1'b0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_number(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_char(s_axis_tdata_i[udhp_pkg::CHAR_W-1:0]);
      end
    end
    pending = expected_numbers.size();
  end

endmodule

/* dv/unsigned_dec_hex_text_parser_tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the unsigned decimal / hexadecimal text parser
// Feeds zero-terminated text strings, first a few hand-picked corner cases
// and then random numbers, broken strings and noise, with random gaps on
// both channels; the scoreboard module checks every result.
// ----------------------------------------------------------------------------
module unsigned_dec_hex_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TERMINATOR = 8'h00;
  localparam int unsigned TARGET_BYTES = 1200;

  typedef logic [7:0] text_t[$];

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic [udhp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [udhp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic                             gaps_on = 1'b1;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned flagged;
  int unsigned bytes_sent = 0;

  always #2 clk_i = ~clk_i;

  unsigned_dec_hex_text_parser #(
    .VALUE_BITS(udhp_pkg::VALUE_BITS_DEF)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  unsigned_dec_hex_text_parser_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .flagged_o      (flagged)
  );

  // The result side stalls at random while gaps are enabled.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (!gaps_on || $urandom_range(99) >= 22);
  end

  // Move one byte across the input channel, with random gaps before it.
  task automatic put_char(logic [7:0] c);
    while (gaps_on && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send a string of bytes followed by its terminator.
  task automatic send_text(text_t text);
    foreach (text[i]) put_char(text[i]);
    put_char(TERMINATOR);
  endtask

  task automatic send_string(string s);
    text_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text);
  endtask

  function automatic logic [7:0] any_space();
    int unsigned w;
    w = $urandom_range(9, 14);
    return (w == 14) ? " " : 8'(w);
  endfunction

  function automatic logic [7:0] digit_char(bit hex);
    int unsigned d;
    logic [7:0]  letter_a;
    d = $urandom_range(hex ? 15 : 9);
    letter_a = $urandom_range(1) ? "A" : "a";
    return (d < 10) ? 8'("0" + d) : 8'(letter_a + d - 10);
  endfunction

  // Build one random string: mostly well-formed numbers, some broken
  // strings, some blank or prefix-only strings, and some noise.
  function automatic text_t random_text();
    text_t       text;
    int unsigned kind;
    int unsigned n;
    bit          hex;
    logic [7:0]  c;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) text.push_back(8'($urandom_range(1, 255)));
      return text;
    end
    repeat ($urandom_range(0, 3)) text.push_back(any_space());
    hex = $urandom_range(1);
    if (kind < 18) begin
      if (hex) text = {text, "0", $urandom_range(1) ? "x" : "X"};
      return text;
    end
    if (hex) text = {text, "0", $urandom_range(1) ? "x" : "X"};
    case ($urandom_range(9))
      0: begin
        // Right at the top of the range, on either side of it.
        if (hex) begin
          repeat (8) text.push_back($urandom_range(1) ? "F" : "f");
          if ($urandom_range(1)) text.push_back(digit_char(1'b1));
        end else begin
          text = {text, "4", "2", "9", "4", "9", "6", "7", "2", "9"};
          text.push_back(digit_char(1'b0));
        end
      end
      1: repeat ($urandom_range(11, 14)) text.push_back(digit_char(hex));
      default: repeat ($urandom_range(1, hex ? 8 : 10)) text.push_back(digit_char(hex));
    endcase
    if (kind < 33) begin
      // A character that is no digit of the base, then junk.
      do c = 8'($urandom_range(1, 255));
      while ((c >= "0" && c <= "9") ||
             (hex && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))));
      text.push_back(c);
      repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(1, 255)));
    end
    return text;
  endfunction

  // Stimulus, end of run and verdict.
  initial begin
    text_t text;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corner cases: empty, blank, prefix only, overflow, invalid bytes.
    send_string("");
    send_string(" \t\r");
    send_string("0X");
    send_string("0x1fFFFFFFF");
    send_string("4294967296");
    send_string("-7");
    text = {8'hFF, "1"};
    send_text(text);
    send_string("0z");

    // Random strings, with a long stretch without gaps in the middle.
    while (bytes_sent < TARGET_BYTES) begin
      gaps_on <= !(bytes_sent >= 500 && bytes_sent < 750);
      send_text(random_text());
    end
    s_axis_tvalid <= 1'b0;
    gaps_on       <= 1'b1;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d text bytes; checked %0d parsed numbers, %0d of them flagged.",
             bytes_sent, results, flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
